/* rtl/nvs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared constants for the NV12 bilinear scaler: store sizes, divider
// geometry, register indexes and request codes.
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int LUMA_AW   = 18;
  localparam int CHROMA_AW = 17;

  localparam int DIV_NW = 28;
  localparam int DIV_DW = 11;
  localparam int DIV_QW = 18;

  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SRC_STRIDE = 3'd2;
  localparam logic [2:0] CFG_DST_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_DST_HEIGHT = 3'd4;

  localparam logic [1:0] REQ_LUMA   = 2'd0;
  localparam logic [1:0] REQ_CHROMA = 2'd1;
  localparam logic [1:0] REQ_PIXEL  = 2'd2;

endpackage
`default_nettype wire

/* rtl/nvs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_ram
// Generic RAM: one write port, two registered read ports, common enable.
// ----------------------------------------------------------------------------
module nvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

/* rtl/nvs_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_div
// Pipelined restoring divider, one quotient bit per stage. The quotient
// must fit DIV_QW bits.
// ----------------------------------------------------------------------------
module nvs_div import nvs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic      [DIV_QW-1:0] quo
);

  logic [DIV_DW-1:0] rem_r [DIV_QW];
  logic [DIV_NW-1:0] num_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];

  for (genvar i = 0; i < DIV_QW; i++) begin : g_stg
    logic [DIV_DW-1:0] rin;
    logic [DIV_NW-1:0] nin;
    logic [DIV_DW-1:0] din;
    logic [DIV_QW-1:0] qin;
    logic [DIV_DW:0]   t;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic [DIV_QW-1:0] qnext;

    if (i == 0) begin : g_first
      assign rin = DIV_DW'(num[DIV_NW-1:DIV_QW]);
      assign nin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_r[i-1];
      assign nin = num_r[i-1];
      assign din = den_r[i-1];
      assign qin = quo_r[i-1];
    end

    assign t    = {rin, nin[DIV_QW-1-i]};
    assign diff = t - {1'b0, din};
    assign ge   = (t >= {1'b0, din});

    always_comb begin
      qnext = qin;
      qnext[DIV_QW-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DIV_DW-1:0] : t[DIV_DW-1:0];
        num_r[i] <= nin;
        den_r[i] <= din;
        quo_r[i] <= qnext;
      end
    end
  end

  assign quo = quo_r[DIV_QW-1];

endmodule
`default_nettype wire

/* rtl/nv12_bilinear_scale_to_rgb_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nv12_bilinear_scale_to_rgb_core
// NV12 frame stores with bilinear luma scaling and BT.601 conversion to RGB.
// ----------------------------------------------------------------------------
// Loads can be accepted back to back; a pixel request also blocks the input
// slot after it, since its four luma samples come from the two read ports of
// the luma memory in consecutive cycles. Requests flow through one in-order
// pipeline (an 18-stage divider maps output to source positions), so a load
// issued after a pixel request never disturbs it. A two-entry output register
// lets new requests in while a result waits. Stores need no clearing pass.
// ----------------------------------------------------------------------------
module nv12_bilinear_scale_to_rgb_core import nvs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [17:0] address,
  input  wire logic [7:0]  byte_value,
  input  wire logic [9:0]  out_x,
  input  wire logic [9:0]  out_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [17:0] addr;
    logic [7:0]  val;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [9:0]  x0;
    logic [9:0]  x1;
    logic [19:0] r0;
    logic [19:0] r1;
    logic [18:0] rc;
    logic [16:0] w00;
    logic [16:0] w01;
    logic [16:0] w10;
    logic [16:0] w11;
  } stage_a_t;

  typedef struct packed {
    side_t                sd;
    logic [LUMA_AW-1:0]   a00;
    logic [LUMA_AW-1:0]   a01;
    logic [LUMA_AW-1:0]   a10;
    logic [LUMA_AW-1:0]   a11;
    logic [CHROMA_AW-1:0] ca;
    logic [CHROMA_AW-1:0] cb;
    logic [16:0]          w00;
    logic [16:0]          w01;
    logic [16:0]          w10;
    logic [16:0]          w11;
  } stage_b_t;

  function automatic logic [7:0] sat8(input logic signed [19:0] v);
    if (v < 0) begin
      return 8'd0;
    end else if (v[19:8] > 12'd255) begin
      return 8'd255;
    end else begin
      return v[15:8];
    end
  endfunction

  // configuration
  logic [9:0]  src_width, src_height, src_stride;
  logic [10:0] dst_width, dst_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= 10'd512;
      src_height <= 10'd512;
      src_stride <= 10'd512;
      dst_width  <= 11'd512;
      dst_height <= 11'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data[9:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[9:0];
        CFG_SRC_STRIDE: src_stride <= cfg_data[9:0];
        CFG_DST_WIDTH:  dst_width  <= cfg_data;
        CFG_DST_HEIGHT: dst_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and input
  logic en, blk, skid_v, acc, keep;

  assign en       = !skid_v;
  assign in_stall = !en || blk;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    case (req_type)
      REQ_LUMA:   keep = 1'b1;
      REQ_CHROMA: keep = !address[17];
      REQ_PIXEL:  keep = ({1'b0, out_x} < dst_width) && ({1'b0, out_y} < dst_height);
      default:    keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk <= 1'b0;
    end else if (en) begin
      blk <= acc && (req_type == REQ_PIXEL);
    end
  end

  side_t      s0;
  logic [9:0] s0_ox, s0_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld <= 1'b0;
    end else if (en) begin
      s0.vld <= acc && keep;
    end
    if (en) begin
      s0.kind <= req_type;
      s0.addr <= address;
      s0.val  <= byte_value;
      s0_ox   <= out_x;
      s0_oy   <= out_y;
    end
  end

  side_t       s1;
  logic [19:0] s1_mx, s1_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (en) begin
      s1.vld <= s0.vld;
    end
    if (en) begin
      s1.kind <= s0.kind;
      s1.addr <= s0.addr;
      s1.val  <= s0.val;
      s1_mx   <= {10'd0, s0_ox} * {10'd0, src_width};
      s1_my   <= {10'd0, s0_oy} * {10'd0, src_height};
    end
  end

  // source position = out * src * 256 / dst
  logic [DIV_QW-1:0] qx, qy;

  nvs_div u_divx (.clk(clk), .en(en), .num({s1_mx, 8'd0}), .den(dst_width), .quo(qx));
  nvs_div u_divy (.clk(clk), .en(en), .num({s1_my, 8'd0}), .den(dst_height), .quo(qy));

  side_t sdp [DIV_QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sdp[0].vld <= 1'b0;
    end else if (en) begin
      sdp[0].vld <= s1.vld;
    end
    if (en) begin
      sdp[0].kind <= s1.kind;
      sdp[0].addr <= s1.addr;
      sdp[0].val  <= s1.val;
    end
    for (int i = 1; i < DIV_QW; i++) begin
      if (rst) begin
        sdp[i].vld <= 1'b0;
      end else if (en) begin
        sdp[i].vld <= sdp[i-1].vld;
      end
      if (en) begin
        sdp[i].kind <= sdp[i-1].kind;
        sdp[i].addr <= sdp[i-1].addr;
        sdp[i].val  <= sdp[i-1].val;
      end
    end
  end

  // neighbors, row bases and weights
  logic [9:0]  x0, y0, x1, y1, lastx, lasty;
  logic [10:0] nx, ny;
  logic [7:0]  fx, fy;
  logic [8:0]  gx, gy;
  stage_a_t    sa_next, sa;

  always_comb begin
    x0    = qx[17:8];
    fx    = qx[7:0];
    y0    = qy[17:8];
    fy    = qy[7:0];
    lastx = (src_width == 10'd0) ? 10'd0 : src_width - 10'd1;
    lasty = (src_height == 10'd0) ? 10'd0 : src_height - 10'd1;
    nx    = {1'b0, x0} + 11'd1;
    ny    = {1'b0, y0} + 11'd1;
    x1    = (nx > {1'b0, lastx}) ? lastx : nx[9:0];
    y1    = (ny > {1'b0, lasty}) ? lasty : ny[9:0];
    gx    = 9'd256 - {1'b0, fx};
    gy    = 9'd256 - {1'b0, fy};
    sa_next.sd  = sdp[DIV_QW-1];
    sa_next.x0  = x0;
    sa_next.x1  = x1;
    sa_next.r0  = {10'd0, y0} * {10'd0, src_stride};
    sa_next.r1  = {10'd0, y1} * {10'd0, src_stride};
    sa_next.rc  = {10'd0, y0[9:1]} * {9'd0, src_stride};
    sa_next.w00 = 17'({9'd0, gx} * {9'd0, gy});
    sa_next.w01 = 17'({10'd0, fx} * {9'd0, gy});
    sa_next.w10 = 17'({9'd0, gx} * {10'd0, fy});
    sa_next.w11 = 17'({10'd0, fx} * {10'd0, fy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.sd.vld <= 1'b0;
    end else if (en) begin
      sa <= sa_next;
    end
  end

  // memory addresses
  stage_b_t sb_next, sb, sc;
  logic [18:0] cofs;

  always_comb begin
    cofs        = {9'd0, sa.x0[9:1], 1'b0};
    sb_next.sd  = sa.sd;
    sb_next.a00 = LUMA_AW'(sa.r0 + {10'd0, sa.x0});
    sb_next.a01 = LUMA_AW'(sa.r0 + {10'd0, sa.x1});
    sb_next.a10 = LUMA_AW'(sa.r1 + {10'd0, sa.x0});
    sb_next.a11 = LUMA_AW'(sa.r1 + {10'd0, sa.x1});
    sb_next.ca  = CHROMA_AW'(sa.rc + cofs);
    sb_next.cb  = CHROMA_AW'(sa.rc + cofs) + CHROMA_AW'(1);
    sb_next.w00 = sa.w00;
    sb_next.w01 = sa.w01;
    sb_next.w10 = sa.w10;
    sb_next.w11 = sa.w11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb.sd.vld <= 1'b0;
      sc.sd.vld <= 1'b0;
    end else if (en) begin
      sb <= sb_next;
      sc <= sb;
    end
  end

  // stores: row y0 and chroma read with the request in sb, row y1 when it
  // reaches sc; the following slot is always empty
  logic                 sb_pix, sc_pix;
  logic [LUMA_AW-1:0]   lra, lrb;
  logic [7:0]           lda, ldb, cda, cdb;

  assign sb_pix = sb.sd.vld && (sb.sd.kind == REQ_PIXEL);
  assign sc_pix = sc.sd.vld && (sc.sd.kind == REQ_PIXEL);
  assign lra    = sc_pix ? sc.a10 : sb.a00;
  assign lrb    = sc_pix ? sc.a11 : sb.a01;

  nvs_ram #(.WIDTH(8), .DEPTH(2 ** LUMA_AW)) u_luma (
    .clk(clk), .en(en),
    .we(sb.sd.vld && (sb.sd.kind == REQ_LUMA)),
    .waddr(sb.sd.addr[LUMA_AW-1:0]), .wdata(sb.sd.val),
    .raddr_a(lra), .raddr_b(lrb), .rdata_a(lda), .rdata_b(ldb)
  );

  nvs_ram #(.WIDTH(8), .DEPTH(2 ** CHROMA_AW)) u_chroma (
    .clk(clk), .en(en),
    .we(sb.sd.vld && (sb.sd.kind == REQ_CHROMA)),
    .waddr(sb.sd.addr[CHROMA_AW-1:0]), .wdata(sb.sd.val),
    .raddr_a(sb.ca), .raddr_b(sb.cb), .rdata_a(cda), .rdata_b(cdb)
  );

  // interpolation and color matrix
  logic        se_vld, sf_vld, sg_vld, sh_vld;
  logic [25:0] se_s0, sf_s0, sf_s1;
  logic [16:0] se_w10, se_w11;
  logic [7:0]  se_u, se_v, sf_u, sf_v;
  logic [24:0] ysum;
  logic signed [19:0] sg_c, sg_d, sg_e;
  logic signed [19:0] sh_c, sh_re, sh_gd, sh_ge, sh_bd;
  logic signed [19:0] rs, gs, bs;

  assign ysum = 25'(sf_s0) + 25'(sf_s1) + 25'd32768;
  assign rs   = sh_c + sh_re + 20'sd128;
  assign gs   = sh_c - sh_gd - sh_ge + 20'sd128;
  assign bs   = sh_c + sh_bd + 20'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_vld <= 1'b0;
      sf_vld <= 1'b0;
      sg_vld <= 1'b0;
      sh_vld <= 1'b0;
    end else if (en) begin
      se_vld <= sc_pix;
      sf_vld <= se_vld;
      sg_vld <= sf_vld;
      sh_vld <= sg_vld;
    end
    if (en) begin
      se_s0  <= 26'({9'd0, sc.w00} * {18'd0, lda}) + 26'({9'd0, sc.w01} * {18'd0, ldb});
      se_w10 <= sc.w10;
      se_w11 <= sc.w11;
      se_u   <= cda;
      se_v   <= cdb;
      sf_s0  <= se_s0;
      sf_s1  <= 26'({9'd0, se_w10} * {18'd0, lda}) + 26'({9'd0, se_w11} * {18'd0, ldb});
      sf_u   <= se_u;
      sf_v   <= se_v;
      sg_c   <= $signed({12'd0, ysum[23:16]}) - 20'sd16;
      sg_d   <= $signed({12'd0, sf_u}) - 20'sd128;
      sg_e   <= $signed({12'd0, sf_v}) - 20'sd128;
      sh_c   <= sg_c * 20'sd298;
      sh_re  <= sg_e * 20'sd409;
      sh_gd  <= sg_d * 20'sd100;
      sh_ge  <= sg_e * 20'sd208;
      sh_bd  <= sg_d * 20'sd516;
    end
  end

  // output register with skid entry
  logic       pop, res_v;
  logic [7:0] skid_r, skid_g, skid_b;

  assign pop   = out_valid && !out_stall;
  assign res_v = en && sh_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid <= skid_v || res_v;
      skid_v    <= 1'b0;
    end else if (res_v) begin
      skid_v <= 1'b1;
    end
    if (!out_valid || pop) begin
      if (skid_v) begin
        red   <= skid_r;
        green <= skid_g;
        blue  <= skid_b;
      end else begin
        red   <= sat8(rs);
        green <= sat8(gs);
        blue  <= sat8(bs);
      end
    end else if (res_v) begin
      skid_r <= sat8(rs);
      skid_g <= sat8(gs);
      skid_b <= sat8(bs);
    end
  end

endmodule
`default_nettype wire

/* rtl/nvs_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvs_chk
// Port-level checks for the NV12 scaler core.
// ----------------------------------------------------------------------------
module nvs_chk import nvs_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [10:0] cfg_data,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  req_type,
  input wire logic [17:0] address,
  input wire logic [7:0]  byte_value,
  input wire logic [9:0]  out_x,
  input wire logic [9:0]  out_y,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({red, green, blue}))
    else $error("stalled result changed");

  a_pixel_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_PIXEL) |=> in_stall)
    else $error("pixel request not followed by a free slot");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind nv12_bilinear_scale_to_rgb_core nvs_chk u_nvs_chk (.*);
`default_nettype wire
